// ----- design/fst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the format string tokenizer.
// -----------------------------------------------------------------------------
package fst_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;

    localparam logic [2:0] TYPE_TEXT   = 3'd0;
    localparam logic [2:0] TYPE_INT    = 3'd1;
    localparam logic [2:0] TYPE_FLOAT  = 3'd2;
    localparam logic [2:0] TYPE_STRING = 3'd3;
    localparam logic [2:0] TYPE_EOF    = 3'd4;

    // Description of one result, without its character.
    typedef struct packed {
        logic       char_valid;
        logic       token_end;
        logic [2:0] token_type;
    } t_desc;

    // One classified character: its first result and an optional second one.
    typedef struct packed {
        logic [7:0] ch;
        t_desc      first;
        logic       two;
        t_desc      second;
    } t_cmd;

    localparam t_desc DESC_CHAR  = '{char_valid: 1'b1, token_end: 1'b0, token_type: TYPE_TEXT};
    localparam t_desc DESC_CLOSE = '{char_valid: 1'b0, token_end: 1'b1, token_type: TYPE_TEXT};
    localparam t_desc DESC_EOF   = '{char_valid: 1'b0, token_end: 1'b1, token_type: TYPE_EOF};

endpackage
`default_nettype wire

// ----- design/fst_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fst_front
// Accepts characters, tracks the scan mode and classifies each character
// into a command for the result queue.
// -----------------------------------------------------------------------------
module fst_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ch_valid,
    input  wire logic [7:0]    i_ch,
    output logic               o_ch_ready,
    input  wire logic          i_q_full,
    output logic               o_push,
    output fst_pkg::t_cmd      o_cmd
);
    import fst_pkg::*;

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_TEXT  = 3'd1;
    localparam logic [2:0] MODE_PCT   = 3'd2;
    localparam logic [2:0] MODE_MINUS = 3'd3;
    localparam logic [2:0] MODE_WIDTH = 3'd4;
    localparam logic [2:0] MODE_PREC  = 3'd5;
    localparam logic [2:0] MODE_LONG  = 3'd6;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic [2:0] w_conv;
    logic       w_digit;
    logic       w_early;

    function automatic logic [2:0] conv_type(input logic [7:0] c);
        logic [2:0] t;
        t = TYPE_TEXT;
        if (c inside {CH_C, CH_D, CH_U, CH_O, CH_X, CH_UPPER_X}) begin
            t = TYPE_INT;
        end else if (c inside {CH_F, CH_E, CH_G}) begin
            t = TYPE_FLOAT;
        end else if (c == CH_S) begin
            t = TYPE_STRING;
        end
        return t;
    endfunction

    assign o_ch_ready = !i_q_full;
    assign o_push     = i_ch_valid && !i_q_full;

    always_comb begin
        w_conv       = conv_type(i_ch);
        w_digit      = i_ch inside {[CH_DIGIT0:CH_DIGIT9]};
        w_early      = (r_mode == MODE_PCT) || (r_mode == MODE_MINUS)
                       || (r_mode == MODE_WIDTH);
        n_mode       = r_mode;
        o_cmd.ch     = i_ch;
        o_cmd.first  = DESC_CHAR;
        o_cmd.two    = 1'b0;
        o_cmd.second = DESC_EOF;
        case (r_mode)
            MODE_TEXT: begin
                if (i_ch == CH_NUL) begin
                    o_cmd.first = DESC_CLOSE;
                    o_cmd.two   = 1'b1;
                    n_mode      = MODE_START;
                end else if (i_ch == CH_PERCENT) begin
                    o_cmd.first  = DESC_CLOSE;
                    o_cmd.two    = 1'b1;
                    o_cmd.second = DESC_CHAR;
                    n_mode       = MODE_PCT;
                end
            end
            MODE_PCT, MODE_MINUS, MODE_WIDTH, MODE_PREC, MODE_LONG: begin
                if (i_ch == CH_NUL) begin
                    o_cmd.first = DESC_CLOSE;
                    o_cmd.two   = 1'b1;
                    n_mode      = MODE_START;
                end else if (r_mode == MODE_PCT && i_ch == CH_PERCENT) begin
                    o_cmd.first = DESC_CLOSE;
                    n_mode      = MODE_START;
                end else if (w_conv != TYPE_TEXT) begin
                    o_cmd.first = '{char_valid: 1'b1, token_end: 1'b1, token_type: w_conv};
                    n_mode      = MODE_START;
                end else if (r_mode == MODE_PCT && i_ch == CH_MINUS) begin
                    n_mode = MODE_MINUS;
                end else if (w_early && w_digit) begin
                    n_mode = MODE_WIDTH;
                end else if (r_mode == MODE_PREC && w_digit) begin
                    n_mode = MODE_PREC;
                end else if (w_early && i_ch == CH_DOT) begin
                    n_mode = MODE_PREC;
                end else if (r_mode != MODE_LONG && i_ch == CH_L) begin
                    n_mode = MODE_LONG;
                end else begin
                    n_mode = MODE_TEXT;
                end
            end
            default: begin
                if (i_ch == CH_NUL) begin
                    o_cmd.first = DESC_EOF;
                    n_mode      = MODE_START;
                end else if (i_ch == CH_PERCENT) begin
                    n_mode = MODE_PCT;
                end else begin
                    n_mode = MODE_TEXT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
        end else if (o_push) begin
            r_mode <= n_mode;
        end
    end

endmodule
`default_nettype wire

// ----- design/fst_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fst_queue
// Small first-in first-out queue of classified commands.
// -----------------------------------------------------------------------------
module fst_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fst_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output fst_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import fst_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- design/fst_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fst_back
// Expands each queued command into one or two results and holds them in
// the output register until taken.
// -----------------------------------------------------------------------------
module fst_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire fst_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output logic [7:0]         o_out_char,
    output logic               o_char_valid,
    output logic               o_token_end,
    output logic [2:0]         o_token_type,
    output logic               o_last
);
    import fst_pkg::*;

    logic       r_valid;
    logic       r_pend_valid;
    t_desc      r_pend_desc;
    logic [7:0] r_pend_ch;
    logic [7:0] r_out_char;
    t_desc      r_out_desc;
    logic       r_last;
    logic       w_load;
    logic       w_take_pend;

    assign w_load      = !r_valid || i_res_ready;
    assign w_take_pend = w_load && r_pend_valid;
    assign o_q_pop     = w_load && !r_pend_valid && i_q_valid;

    assign o_res_valid  = r_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_out_desc.char_valid;
    assign o_token_end  = r_out_desc.token_end;
    assign o_token_type = r_out_desc.token_type;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_take_pend) begin
            r_valid      <= 1'b1;
            r_pend_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid      <= 1'b1;
            r_pend_valid <= i_q_cmd.two;
        end else if (w_load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_pend) begin
            r_out_desc <= r_pend_desc;
            r_out_char <= r_pend_desc.char_valid ? r_pend_ch : 8'h00;
            r_last     <= 1'b1;
        end else if (o_q_pop) begin
            r_out_desc  <= i_q_cmd.first;
            r_out_char  <= i_q_cmd.first.char_valid ? i_q_cmd.ch : 8'h00;
            r_last      <= !i_q_cmd.two;
            r_pend_desc <= i_q_cmd.second;
            r_pend_ch   <= i_q_cmd.ch;
        end
    end

`ifndef NO_ASSERTIONS
    a_pend_behind_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_valid && !r_last))
        else $error("A second result is pending while no first result is shown.");

    a_pend_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> ((r_pend_desc.token_end && r_pend_desc.token_type == TYPE_EOF)
                          || (r_pend_desc.char_valid && r_pend_ch == CH_PERCENT)))
        else $error("A pending second result is neither end of string nor a percent sign.");

    a_no_pop_with_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !o_q_pop)
        else $error("The queue was read while a second result was pending.");

    a_pend_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && i_res_ready) |=> (r_valid && r_last))
        else $error("A pending second result did not follow its first result.");
`endif

endmodule
`default_nettype wire

// ----- design/format_spec_tokenizer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// format_spec_tokenizer_top
// Splits a printf-style format string, one character per request, into
// text, int, float, string and end-of-string tokens.
//
//   Channel   Direction  Handshake                 Payload
//   char      in         i_ch_valid / o_ch_ready   i_ch
//   result    out        o_res_valid / i_res_ready o_out_char, o_char_valid,
//                                                  o_token_end, o_token_type,
//                                                  o_last
//
// One character is accepted per cycle while the command queue has room.
// An accepted character is written into the command queue; its result is
// then registered in the output register. A character that closes a token
// and starts or ends another gives two results, one after the other; the
// queue of QUEUE_DEPTH commands absorbs short bursts of these and short
// output stalls, and o_ch_ready falls while the queue is full.
// Reset clears the scan mode, the queue and the output register.
// -----------------------------------------------------------------------------
module format_spec_tokenizer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_ch_valid,
    output logic            o_ch_ready,
    input  wire logic [7:0] i_ch,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic            o_token_end,
    output logic [2:0]      o_token_type,
    output logic            o_last
);
    import fst_pkg::*;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    fst_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch_valid (i_ch_valid),
        .i_ch       (i_ch),
        .o_ch_ready (o_ch_ready),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    fst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    fst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_q_pop),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_token_end  (o_token_end),
        .o_token_type (o_token_type),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire
